// ----- rtl/cbp_pkg.sv -----
// ----------------------------------------------------------------------------
// Code table bit packer package
// Shared widths, operation codes, limits and the code table entry type.
// ----------------------------------------------------------------------------
package cbp_pkg;

	// Field widths of the item and word channels.
	localparam int OP_W           = 2;
	localparam int CODE_W         = 32;
	localparam int CODE_LEN_W     = 6;
	localparam int WORD_W         = 32;
	localparam int FILL_W         = 5;
	localparam int BIT_COUNT_W    = 16;
	localparam int WORD_COUNT_W   = 12;

	// Defaults for the top level parameters.
	localparam int SYMBOL_BITS_DEF     = 12;
	localparam int MAX_CODE_LENGTH_DEF = 32;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
	localparam logic [OP_W-1:0] OP_END    = 2'd2;

	// Saturation limits of the counters.
	localparam logic [BIT_COUNT_W-1:0]  BITS_MAX  = '1;
	localparam logic [WORD_COUNT_W-1:0] WORDS_MAX = '1;

	// One code table entry: left-aligned code and its length.
	typedef struct packed {
		logic [CODE_W-1:0]     code;
		logic [CODE_LEN_W-1:0] len;
	} entry_t;

endpackage

// ----- rtl/cbp_item_if.sv -----
// ----------------------------------------------------------------------------
// Code table bit packer item channel
// Valid/ready channel that carries load, encode and end items.
// ----------------------------------------------------------------------------
interface cbp_item_if #(
	parameter int SYMBOL_BITS = cbp_pkg::SYMBOL_BITS_DEF
);
	import cbp_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [OP_W-1:0]        operation;
	logic [SYMBOL_BITS-1:0] symbol;
	logic [CODE_W-1:0]      code_bits;
	logic [CODE_LEN_W-1:0]  code_length;

	modport source (
		output valid, operation, symbol, code_bits, code_length,
		input  ready
	);

	modport sink (
		input  valid, operation, symbol, code_bits, code_length,
		output ready
	);

endinterface

// ----- rtl/cbp_word_if.sv -----
// ----------------------------------------------------------------------------
// Code table bit packer word channel
// Valid/ready channel that carries packed words and the closing counts.
// ----------------------------------------------------------------------------
interface cbp_word_if;
	import cbp_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [WORD_W-1:0]       packed_word;
	logic                    is_final;
	logic [BIT_COUNT_W-1:0]  bit_count;
	logic [WORD_COUNT_W-1:0] word_count;

	modport source (
		output valid, packed_word, is_final, bit_count, word_count,
		input  ready
	);

	modport sink (
		input  valid, packed_word, is_final, bit_count, word_count,
		output ready
	);

endinterface

// ----- rtl/code_table_bit_packer_unit.sv -----
// ----------------------------------------------------------------------------
// Code table bit packer
// Holds a prefix code per symbol and packs encoded symbols MSB first into
// 32-bit words; an end item closes the string with its bit and word counts.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Carries
//   -------   ---   ------------------------------------------------------
//   items     in    operation, symbol, code_bits, code_length
//   words     out   packed_word, is_final, bit_count, word_count
//
// One item is taken per cycle unless a stalled word holds the read stage. An
// accepted item passes through the table read stage register, and its word,
// if any, then lands in the output register.
// The code table is a single-port memory: a load writes it at acceptance,
// and an encode reads it at acceptance, so a load followed at once by an
// encode of the same symbol sees the new entry.
// Reset clears the packer state and both stage valids; the table is not
// cleared and holds garbage until loaded. A stalled word holds the read
// stage, which in turn drops ready on the item side.
module code_table_bit_packer_unit #(
	parameter int SYMBOL_BITS     = cbp_pkg::SYMBOL_BITS_DEF,
	parameter int MAX_CODE_LENGTH = cbp_pkg::MAX_CODE_LENGTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	cbp_item_if.sink     items,
	cbp_word_if.source   words
);
	import cbp_pkg::*;

	localparam int TABLE_DEPTH = 1 << SYMBOL_BITS;
	localparam logic [CODE_LEN_W-1:0] LEN_MAX = CODE_LEN_W'(MAX_CODE_LENGTH);

	// Code table.
	entry_t mem [TABLE_DEPTH];

	// Read stage.
	logic            valid_s1;
	logic [OP_W-1:0] op_s1;
	entry_t          rd_s1;

	// Packer state.
	logic [WORD_W-1:0]       acc_q;
	logic [FILL_W-1:0]       fill_q;
	logic [BIT_COUNT_W-1:0]  total_q;
	logic [WORD_COUNT_W-1:0] words_q;

	// Output register.
	logic                    out_valid_q;
	logic [WORD_W-1:0]       out_word_q;
	logic                    out_final_q;
	logic [BIT_COUNT_W-1:0]  out_bits_q;
	logic [WORD_COUNT_W-1:0] out_words_q;

	logic   advance;
	logic   accept;
	logic   keep_item;
	entry_t load_entry;
	logic [CODE_LEN_W-1:0]   load_len;

	logic [FILL_W+1:0]       end_sum;
	logic                    wrap;
	logic [WORD_W-1:0]       acc_or;
	logic [WORD_W-1:0]       spill;
	logic [CODE_LEN_W:0]     spill_amt;
	logic [BIT_COUNT_W:0]    total_sum;
	logic [BIT_COUNT_W-1:0]  total_next;
	logic [WORD_COUNT_W-1:0] words_inc;
	logic                    is_enc;
	logic                    is_end;
	logic                    emit;

	// Handshake: the output register frees when empty or being taken.
	assign advance     = !out_valid_q || words.ready;
	assign items.ready = !valid_s1 || advance;
	assign accept      = items.valid && items.ready;
	assign keep_item   = (items.operation == OP_ENCODE) || (items.operation == OP_END);

	// Load entry: saturate the length and clear code bits below it.
	always_comb begin
		load_len = (items.code_length > LEN_MAX) ? LEN_MAX : items.code_length;
		load_entry.len  = load_len;
		load_entry.code = items.code_bits & ~({CODE_W{1'b1}} >> load_len);
	end

	// Table write and registered read at acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (items.operation == OP_LOAD) begin
				mem[items.symbol] <= load_entry;
			end
			rd_s1 <= mem[items.symbol];
			op_s1 <= items.operation;
		end
	end

	// Read stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= accept && keep_item;
		end
	end

	// Packing logic: append the code at the fill position.
	always_comb begin
		is_enc     = valid_s1 && (op_s1 == OP_ENCODE);
		is_end     = valid_s1 && (op_s1 == OP_END);
		end_sum    = {2'b00, fill_q} + {1'b0, rd_s1.len};
		wrap       = end_sum[FILL_W];
		acc_or     = acc_q | (rd_s1.code >> fill_q);
		spill_amt  = (CODE_LEN_W+1)'(WORD_W) - {2'b00, fill_q};
		spill      = rd_s1.code << spill_amt;
		total_sum  = {1'b0, total_q} + (BIT_COUNT_W+1)'(rd_s1.len);
		total_next = total_sum[BIT_COUNT_W] ? BITS_MAX : total_sum[BIT_COUNT_W-1:0];
		words_inc  = (words_q == WORDS_MAX) ? WORDS_MAX : words_q + 1'b1;
		emit       = (is_enc && wrap) || is_end;
	end

	// Packer state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			fill_q  <= '0;
			total_q <= '0;
			words_q <= '0;
		end else if (advance) begin
			if (is_enc) begin
				acc_q   <= wrap ? spill : acc_or;
				fill_q  <= end_sum[FILL_W-1:0];
				total_q <= total_next;
				if (wrap) begin
					words_q <= words_inc;
				end
			end else if (is_end) begin
				acc_q   <= '0;
				fill_q  <= '0;
				total_q <= '0;
				words_q <= '0;
			end
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_word_q  <= is_end ? acc_q : acc_or;
			out_final_q <= is_end;
			out_bits_q  <= is_end ? total_q : '0;
			out_words_q <= is_end ? words_inc : '0;
		end
	end

	assign words.valid       = out_valid_q;
	assign words.packed_word = out_word_q;
	assign words.is_final    = out_final_q;
	assign words.bit_count   = out_bits_q;
	assign words.word_count  = out_words_q;

endmodule

// ----- tb/cbp_pack_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Code table bit packer checker
// Watches the item and word channels, keeps its own code table and packing
// state, predicts every word and compares each accepted word field by field.
// ----------------------------------------------------------------------------
module cbp_pack_checker (
	input  logic clk,
	input  logic arst_n,
	cbp_item_if  items,
	cbp_word_if  words,
	output int   error_count,
	output int   words_pending
);
	import cbp_pkg::*;

	localparam int                    SYMBOLS = 1 << SYMBOL_BITS_DEF;
	localparam logic [CODE_LEN_W-1:0] MAX_LEN = CODE_LEN_W'(MAX_CODE_LENGTH_DEF);

	// One predicted word with its closing counts.
	typedef struct packed {
		logic [WORD_W-1:0]       word;
		logic                    fin;
		logic [BIT_COUNT_W-1:0]  bits;
		logic [WORD_COUNT_W-1:0] count;
	} word_result_t;

	// Shadow code table and packing state.
	logic [CODE_W-1:0]       table_code [SYMBOLS];
	logic [CODE_LEN_W-1:0]   table_len  [SYMBOLS];
	logic [WORD_W-1:0]       acc;
	logic [FILL_W-1:0]       fill;
	logic [BIT_COUNT_W-1:0]  total_bits;
	logic [WORD_COUNT_W-1:0] full_words;

	word_result_t expected_words [$];

	// Applies one accepted item to the shadow state and queues its word, if any.
	task automatic pack_item(input logic [OP_W-1:0] op,
			input logic [SYMBOL_BITS_DEF-1:0] sym,
			input logic [CODE_W-1:0] code_in,
			input logic [CODE_LEN_W-1:0] len_in);
		logic [CODE_W-1:0]       code;
		logic [CODE_LEN_W-1:0]   len;
		logic [6:0]              fill_end;
		logic [BIT_COUNT_W:0]    bit_sum;
		logic [WORD_COUNT_W:0]   closing_count;
		case (op)
			OP_LOAD: begin
				// Saturate the length and clear code bits below it.
				len = (len_in > MAX_LEN) ? MAX_LEN : len_in;
				code = code_in & ~(32'hFFFF_FFFF >> len);
				table_code[sym] = code;
				table_len[sym] = len;
			end
			OP_ENCODE: begin
				code = table_code[sym];
				len = table_len[sym];
				fill_end = 7'(fill) + 7'(len);
				acc = acc | (code >> fill);
				bit_sum = (BIT_COUNT_W + 1)'(total_bits) + (BIT_COUNT_W + 1)'(len);
				total_bits = (bit_sum > BITS_MAX) ? BITS_MAX : bit_sum[BIT_COUNT_W-1:0];
				// A filled word goes out; the bits that spill over start the next one.
				if (fill_end >= 7'(WORD_W)) begin
					expected_words.insert(expected_words.size(), '{acc, 1'b0, '0, '0});
					if (full_words != WORDS_MAX)
						full_words = full_words + 1'b1;
					acc = (fill == '0) ? '0 : code << (WORD_W - int'(fill));
				end
				fill = fill_end[FILL_W-1:0];
			end
			OP_END: begin
				closing_count = (WORD_COUNT_W + 1)'(full_words) + 1'b1;
				if (closing_count > WORDS_MAX)
					closing_count = (WORD_COUNT_W + 1)'(WORDS_MAX);
				expected_words.insert(expected_words.size(), '{acc, 1'b1, total_bits,
					closing_count[WORD_COUNT_W-1:0]});
				acc = '0;
				fill = '0;
				total_bits = '0;
				full_words = '0;
			end
			default: begin
			end
		endcase
	endtask

	// Predict on item acceptance, then check any word accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc = '0;
			fill = '0;
			total_bits = '0;
			full_words = '0;
			expected_words.delete();
			words_pending <= 0;
		end else begin : track
			word_result_t want;
			int           errs;
			errs = 0;
			if (items.valid && items.ready)
				pack_item(items.operation, items.symbol, items.code_bits, items.code_length);
			if (words.valid && words.ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: packed_word %h, is_final %b",
						words.packed_word, words.is_final);
					errs = 1;
				end else begin
					want = expected_words.pop_front();
					if (words.packed_word !== want.word) begin
						$error("packed_word: expected %h, got %h", want.word, words.packed_word);
						errs++;
					end
					if (words.is_final !== want.fin) begin
						$error("is_final: expected %b, got %b", want.fin, words.is_final);
						errs++;
					end
					if (words.bit_count !== want.bits) begin
						$error("bit_count: expected %0d, got %0d", want.bits, words.bit_count);
						errs++;
					end
					if (words.word_count !== want.count) begin
						$error("word_count: expected %0d, got %0d", want.count, words.word_count);
						errs++;
					end
				end
			end
			error_count <= error_count + errs;
			words_pending <= expected_words.size();
		end
	end

endmodule

// ----- tb/code_table_bit_packer_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Code table bit packer testbench
// Loads prefix codes and packs directed and random strings through the block,
// including a long string of full-length codes, with random gaps on the item
// side and random stalls on the word side; the checker compares.
// ----------------------------------------------------------------------------
module code_table_bit_packer_unit_tb;
	import cbp_pkg::*;

	localparam int              SYMBOLS     = 1 << SYMBOL_BITS_DEF;
	localparam int              CYCLE_LIMIT = 400000;
	localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	int   error_count;
	int   words_pending;
	int   cycles;
	int   stall_left;
	bit   idle_on;

	// Symbols that hold a loaded entry; only these are ever encoded.
	bit                         loaded [SYMBOLS];
	logic [SYMBOL_BITS_DEF-1:0] loaded_syms [$];

	always #5 clk = ~clk;

	cbp_item_if items_if ();
	cbp_word_if words_if ();

	code_table_bit_packer_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_if),
		.words  (words_if)
	);

	cbp_pack_checker pack_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.items         (items_if),
		.words         (words_if),
		.error_count   (error_count),
		.words_pending (words_pending)
	);

	// Word side stalls in bursts of random length while idling is on.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			words_if.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 6);
			words_if.ready <= 1'b0;
		end else begin
			words_if.ready <= 1'b1;
		end
	end

	// Guard against a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[code_table_bit_packer_unit] ERROR");
			$finish;
		end
	end

	// Presents one item on the item channel and waits until it is taken.
	task automatic send_item(input logic [OP_W-1:0] op,
			input logic [SYMBOL_BITS_DEF-1:0] sym,
			input logic [CODE_W-1:0] code,
			input logic [CODE_LEN_W-1:0] len);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			items_if.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.operation <= op;
		items_if.symbol <= sym;
		items_if.code_bits <= code;
		items_if.code_length <= len;
		do @(posedge clk); while (!items_if.ready);
	endtask

	task automatic load_code(input logic [SYMBOL_BITS_DEF-1:0] sym,
			input logic [CODE_W-1:0] code,
			input logic [CODE_LEN_W-1:0] len);
		send_item(OP_LOAD, sym, code, len);
		if (!loaded[sym]) begin
			loaded[sym] = 1'b1;
			loaded_syms.insert(loaded_syms.size(), sym);
		end
	endtask

	task automatic encode_symbol(input logic [SYMBOL_BITS_DEF-1:0] sym);
		send_item(OP_ENCODE, sym, $urandom, CODE_LEN_W'($urandom));
	endtask

	task automatic end_string();
		send_item(OP_END, SYMBOL_BITS_DEF'($urandom), $urandom, CODE_LEN_W'($urandom));
	endtask

	// Mostly encodes of loaded symbols, with loads, string ends and unused items mixed in.
	task automatic random_item();
		int                    pick;
		logic [CODE_LEN_W-1:0] len;
		pick = $urandom_range(0, 99);
		if (pick < 15 || loaded_syms.size() == 0) begin
			len = ($urandom_range(0, 7) == 0) ? CODE_LEN_W'($urandom_range(33, 63))
				: CODE_LEN_W'($urandom_range(0, 32));
			load_code(SYMBOL_BITS_DEF'($urandom_range(0, SYMBOLS - 1)), $urandom, len);
		end else if (pick < 85) begin
			encode_symbol(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
		end else if (pick < 95) begin
			end_string();
		end else begin
			send_item(OP_UNUSED, SYMBOL_BITS_DEF'($urandom), $urandom, CODE_LEN_W'($urandom));
		end
	endtask

	// Holds the item side until every predicted word has come out.
	task automatic drain_words();
		items_if.valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		items_if.valid <= 1'b0;
		items_if.operation <= OP_LOAD;
		items_if.symbol <= '0;
		items_if.code_bits <= '0;
		items_if.code_length <= '0;
		idle_on = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: aligned end on an empty string, then table corner cases.
		end_string();
		load_code(12'd0, 32'hFFFF_FFFF, 6'd32);
		load_code(12'd4095, 32'hFFFF_FFFF, 6'd0);
		load_code(12'd1, 32'hA5A5_5A5A, 6'd63);
		load_code(12'd2, 32'hFFFF_FFFF, 6'd5);
		load_code(12'd3, 32'h8000_0000, 6'd1);
		load_code(12'd4, 32'h5555_5555, 6'd31);
		// Two full codes fill words exactly, so the closing word is empty.
		encode_symbol(12'd0);
		encode_symbol(12'd1);
		end_string();
		// Codes that straddle word boundaries, a zero-length code and an unused item.
		encode_symbol(12'd2);
		encode_symbol(12'd4095);
		encode_symbol(12'd4);
		send_item(OP_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 6'd63);
		encode_symbol(12'd3);
		encode_symbol(12'd0);
		// A load followed at once by an encode of the same symbol.
		load_code(12'd5, 32'hC000_0000, 6'd2);
		encode_symbol(12'd5);
		load_code(12'd6, 32'hDEAD_BEEF, 6'd17);
		encode_symbol(12'd6);
		end_string();
		send_item(OP_UNUSED, '0, '0, '0);

		// Random strings with idling switched on and off in stretches.
		for (int i = 0; i < 650; i++) begin
			if (i % 64 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (i == 325)
				drain_words();
			random_item();
		end
		end_string();

		// One long string of full-length codes fills a word with every symbol.
		idle_on = 1'b1;
		load_code(12'd0, $urandom | 32'h0000_0001, 6'd32);
		for (int i = 0; i < 250; i++)
			encode_symbol(12'd0);
		end_string();

		// Closing stretch without idling on either side.
		idle_on = 1'b0;
		for (int i = 0; i < 170; i++)
			random_item();
		end_string();

		drain_words();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("[code_table_bit_packer_unit] OK");
		else
			$display("[code_table_bit_packer_unit] ERROR");
		$finish;
	end

endmodule

// ----- code_table_bit_packer_unit.f -----
rtl/cbp_pkg.sv
rtl/cbp_item_if.sv
rtl/cbp_word_if.sv
rtl/code_table_bit_packer_unit.sv
tb/cbp_pack_checker.sv
tb/code_table_bit_packer_unit_tb.sv
